>>> hdl/ids_pkg.sv
// ----------------------------------------------------------------------------
// ids_pkg
// Shared types and constants for the indexed deque store: command and
// result words, operation codes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package ids_pkg;

   localparam int OP_W     = 4;
   localparam int POS_W    = 16;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 9;
   // wide enough for any element count and any position
   localparam int CMP_W    = 17;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_BACK  = 4'd0,
      OP_PUSH_FRONT = 4'd1,
      OP_POP_FRONT  = 4'd2,
      OP_POP_BACK   = 4'd3,
      OP_PEEK_FRONT = 4'd4,
      OP_PEEK_BACK  = 4'd5,
      OP_READ_AT    = 4'd6,
      OP_INSERT_AT  = 4'd7,
      OP_REMOVE_AT  = 4'd8,
      OP_CLEAR      = 4'd9
   } ids_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } ids_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_INS_WR,
      S_DONE
   } ids_state_type;

   // command word handed from the port side to the core
   typedef struct packed {
      logic                     valid;
      ids_op_type               op;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } ids_cmd_type;

   // finished result word offered by the core
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] data;
      ids_status_type           status;
      logic [COUNT_W-1:0]       count;
      logic                     empty_res;
   } ids_res_type;

endpackage

>>> hdl/ids_addr.sv
// ----------------------------------------------------------------------------
// ids_addr
// Shared address unit: maps a logical element index onto a physical slot
// of the circular store, (head + index) modulo the capacity.
// ----------------------------------------------------------------------------
module ids_addr
   import ids_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic [$clog2(CAPACITY)-1:0] head,
   input  logic [$clog2(CAPACITY)-1:0] idx,
   output logic [$clog2(CAPACITY)-1:0] phys
);

   localparam int AW = $clog2(CAPACITY);
   localparam logic [AW:0] CAP_W = (AW+1)'(CAPACITY);

   logic [AW:0] sum_wide;
   logic [AW:0] sum_wrap;

   // one add, one compare and subtract; both operands are below capacity
   assign sum_wide = {1'b0, head} + {1'b0, idx};
   assign sum_wrap = sum_wide - CAP_W;
   assign phys     = (sum_wide >= CAP_W) ? sum_wrap[AW-1:0] : sum_wide[AW-1:0];

endmodule

>>> hdl/ids_core.sv
// ----------------------------------------------------------------------------
// ids_core
// Sequencer, circular element store and bookkeeping. End operations use
// the address unit for the access, pop front once more for the new head;
// insert and remove move elements singly (read, write neighbor slot) via it.
// ----------------------------------------------------------------------------
module ids_core
   import ids_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  ids_cmd_type cmd,
   output logic        ready,
   output ids_res_type res,
   input  logic        res_take
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // control and bookkeeping registers
   ids_state_type            state_ff, state_in;
   ids_op_type               op_ff, op_in;
   logic [AW-1:0]            pos_ff, pos_in;
   logic [AW-1:0]            src_ff, src_in;
   logic [AW-1:0]            head_ff, head_in;
   logic [CW-1:0]            count_ff, count_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic signed [DATA_W-1:0] data_ff, data_in;
   ids_status_type           status_ff, status_in;

   // store and its port
   logic signed [DATA_W-1:0] mem_array [CAPACITY];
   logic signed [DATA_W-1:0] rdata_ff;
   logic signed [DATA_W-1:0] mem_wdata;
   logic                     mem_we;
   logic                     mem_re;

   // address unit hookup
   logic [AW-1:0] unit_idx;
   logic [AW-1:0] phys;

   // decode helpers
   logic [CMP_W-1:0] count_wide;
   logic [CMP_W-1:0] pos_wide;
   logic             full;
   logic             empty;
   logic             in_range;
   logic             pos_over;
   logic             pos_at_end;
   logic [AW-1:0]    pos_a;
   logic [AW-1:0]    ins_p;
   logic [AW-1:0]    count_lo;
   logic [AW-1:0]    count_m1;
   logic [CW-1:0]    count_dec;

   ids_addr #(
      .CAPACITY(CAPACITY)
   ) u_addr (
      .head(head_ff),
      .idx (unit_idx),
      .phys(phys)
   );

   // decode against the current fill
   assign count_wide = CMP_W'(count_ff);
   assign pos_wide   = CMP_W'(cmd.position);
   assign full       = (count_ff == CW'(CAPACITY));
   assign empty      = (count_ff == '0);
   assign in_range   = (pos_wide < count_wide);
   assign pos_over   = (pos_wide > count_wide);
   assign pos_at_end = (pos_wide == count_wide);
   assign pos_a      = cmd.position[AW-1:0];
   assign ins_p      = empty ? '0 : pos_a;
   assign count_lo   = count_ff[AW-1:0];
   assign count_dec  = count_ff - CW'(1);
   assign count_m1   = count_dec[AW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.valid) begin
               unique case (cmd.op)
                  OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
                     state_in = empty ? S_DONE : S_READ;
                  end
                  OP_READ_AT, OP_REMOVE_AT: begin
                     state_in = in_range ? S_READ : S_DONE;
                  end
                  OP_INSERT_AT: begin
                     if (full || empty || pos_over || pos_at_end) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_SHIFT_RD;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_READ: begin
            if (op_ff == OP_REMOVE_AT && pos_ff != count_m1) begin
               state_in = S_SHIFT_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SHIFT_RD: begin
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            if (op_ff == OP_INSERT_AT) begin
               state_in = (src_ff == pos_ff) ? S_INS_WR : S_SHIFT_RD;
            end else begin
               state_in = (src_ff == count_m1) ? S_DONE : S_SHIFT_RD;
            end
         end
         S_INS_WR: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath control and register next values
   always_comb begin
      op_in     = op_ff;
      pos_in    = pos_ff;
      src_in    = src_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      value_in  = value_ff;
      data_in   = data_ff;
      status_in = status_ff;
      unit_idx  = '0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_wdata = value_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.valid) begin
               op_in     = cmd.op;
               value_in  = cmd.value;
               pos_in    = ins_p;
               data_in   = '0;
               status_in = STAT_OK;
               unique case (cmd.op)
                  OP_PUSH_BACK: begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        unit_idx  = count_lo;
                        mem_we    = 1'b1;
                        mem_wdata = cmd.value;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  OP_PUSH_FRONT: begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        // head minus one, modulo capacity
                        unit_idx  = AW'(CAPACITY - 1);
                        mem_we    = 1'b1;
                        mem_wdata = cmd.value;
                        head_in   = phys;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  OP_POP_FRONT, OP_PEEK_FRONT: begin
                     if (empty) begin
                        data_in   = 32'sd1;
                        status_in = STAT_RANGE;
                     end else begin
                        unit_idx = '0;
                        mem_re   = 1'b1;
                     end
                  end
                  OP_POP_BACK, OP_PEEK_BACK: begin
                     if (empty) begin
                        data_in   = 32'sd1;
                        status_in = STAT_RANGE;
                     end else begin
                        unit_idx = count_m1;
                        mem_re   = 1'b1;
                     end
                  end
                  OP_READ_AT: begin
                     if (in_range) begin
                        unit_idx = pos_a;
                        mem_re   = 1'b1;
                     end else begin
                        status_in = STAT_RANGE;
                     end
                  end
                  OP_REMOVE_AT: begin
                     if (in_range) begin
                        unit_idx = pos_a;
                        mem_re   = 1'b1;
                        src_in   = pos_a + AW'(1);
                     end else begin
                        data_in   = 32'sd1;
                        status_in = STAT_RANGE;
                     end
                  end
                  OP_INSERT_AT: begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else if (!empty && pos_over) begin
                        status_in = STAT_RANGE;
                     end else if (empty || pos_at_end) begin
                        // no gap to open: write straight at the slot
                        unit_idx  = ins_p;
                        mem_we    = 1'b1;
                        mem_wdata = cmd.value;
                        count_in  = count_ff + CW'(1);
                     end else begin
                        src_in = count_m1;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            data_in = rdata_ff;
            if (op_ff == OP_POP_FRONT) begin
               unit_idx = AW'(1);
               head_in  = phys;
               count_in = count_dec;
            end else if (op_ff == OP_POP_BACK) begin
               count_in = count_dec;
            end else if (op_ff == OP_REMOVE_AT && pos_ff == count_m1) begin
               count_in = count_dec;
            end
         end
         S_SHIFT_RD: begin
            unit_idx = src_ff;
            mem_re   = 1'b1;
         end
         S_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_wdata = rdata_ff;
            if (op_ff == OP_INSERT_AT) begin
               // move up one slot, walking toward the front
               unit_idx = src_ff + AW'(1);
               if (src_ff != pos_ff) begin
                  src_in = src_ff - AW'(1);
               end
            end else begin
               // move down one slot, walking toward the back
               unit_idx = src_ff - AW'(1);
               if (src_ff == count_m1) begin
                  count_in = count_dec;
               end else begin
                  src_in = src_ff + AW'(1);
               end
            end
         end
         S_INS_WR: begin
            unit_idx  = pos_ff;
            mem_we    = 1'b1;
            mem_wdata = value_ff;
            count_in  = count_ff + CW'(1);
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      src_ff    <= src_in;
      value_ff  <= value_in;
      data_ff   <= data_in;
      status_ff <= status_in;
   end

   // element store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_array[phys] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem_array[phys];
      end
   end

   assign ready         = (state_ff == S_IDLE);
   assign res.valid     = (state_ff == S_DONE);
   assign res.data      = data_ff;
   assign res.status    = status_ff;
   assign res.count     = count_wide[COUNT_W-1:0];
   assign res.empty_res = empty;

   // fill never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("element count above capacity");

   // one store access per cycle
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("store read and write in the same cycle");

   // a shift write always follows the read of its source
   a_shift_pair: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT_WR |-> $past(state_ff) == S_SHIFT_RD)
      else $error("shift write without preceding read");

   // the shift source always lies inside the stored elements
   a_src_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT_RD |-> CW'(src_ff) < count_ff)
      else $error("shift source outside stored elements");

endmodule

>>> hdl/indexed_deque_store_top.sv
// ----------------------------------------------------------------------------
// indexed_deque_store_top
// Bounded ordered sequence of signed words with end and indexed access.
//
//   channel  dir  handshake           words
//   req_     in   req_valid/req_stall op, position, value
//   rsp_     out  rsp_valid/rsp_stall data, status, count, empty_res
//
// Push, clear, insert at the end, errors and unused codes finish straight
// from idle; pop, peek and read add a store read; remove at p moves
// count-1-p elements; insert at p below the count moves count-p elements
// and then writes the value. Each moved element is read and then written
// through the single store port and address unit.
// A new word is taken once the previous result sits in the output register.
// Reset is synchronous; there is no clearing pass.
// rsp_stall holds the result register; the core waits until it drains.
// ----------------------------------------------------------------------------
module indexed_deque_store_top
   import ids_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OP_W-1:0]          req_op,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_data,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [COUNT_W-1:0]       rsp_count,
   output logic                     rsp_empty_res
);

   ids_cmd_type cmd;
   ids_res_type res;
   logic        core_ready;
   logic        res_take;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff;
   ids_status_type           rsp_status_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic                     rsp_empty_ff;

   // command word into the core
   assign req_stall    = !core_ready;
   assign cmd.valid    = req_valid && core_ready;
   assign cmd.op       = ids_op_type'(req_op);
   assign cmd.position = req_position;
   assign cmd.value    = req_value;

   ids_core #(
      .CAPACITY(CAPACITY)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .ready   (core_ready),
      .res     (res),
      .res_take(res_take)
   );

   // output register: loads when empty or draining this cycle
   assign res_take     = res.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = res_take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff   <= res.data;
         rsp_status_ff <= res.status;
         rsp_count_ff  <= res.count;
         rsp_empty_ff  <= res.empty_res;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_empty_res = rsp_empty_ff;

endmodule
